FILE: rtl/bsed_pkg.sv
// Shared types, constants and position flags for the binary Sobel edge detector.
`default_nettype none
package bsed_pkg;

	localparam int IMG_WIDTH  = 256;
	localparam int IMG_HEIGHT = 256;

	localparam int PIX_W    = 8;
	localparam int THR_W    = 10;
	localparam int COL_W    = $clog2(IMG_WIDTH);
	localparam int ROW_W    = $clog2(IMG_HEIGHT + 3);
	localparam int BL_DEPTH = 2 * IMG_WIDTH + 2;
	localparam int EL_DEPTH = 2 * IMG_WIDTH;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [THR_W-1:0] thr_t;
	typedef logic [COL_W-1:0] col_t;
	typedef logic [ROW_W-1:0] row_t;

	localparam thr_t THR_RESET = thr_t'(384);
	localparam pix_t PIX_WHITE = pix_t'(255);
	localparam pix_t PIX_BLACK = pix_t'(0);

	typedef struct packed {
		logic in_frame;
		logic q_valid;
		logic emit;
		logic last;
		logic col_first;
		logic col_last;
		logic row_first;
		logic row_last;
		logic row_ge2;
	} pos_t;

endpackage
`default_nettype wire

FILE: rtl/bsed_pos.sv
// Raster position counter over the extended frame and the border flags derived from it.
`default_nettype none
module bsed_pos (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           step,
	output bsed_pkg::pos_t pos
);
	import bsed_pkg::*;

	row_t row_q;
	col_t col_q;
	row_t qi;
	col_t qj;
	logic col_zero;
	logic q_ge0;

	always_comb begin
		col_zero      = (col_q == '0);
		q_ge0         = (row_q >= row_t'(2)) || ((row_q == row_t'(1)) && !col_zero);
		qi            = row_q - row_t'(1) - {{(ROW_W-1){1'b0}}, col_zero};
		qj            = col_zero ? col_t'(IMG_WIDTH - 1) : col_q - col_t'(1);
		pos.in_frame  = (row_q < row_t'(IMG_HEIGHT));
		pos.q_valid   = q_ge0 && (qi < row_t'(IMG_HEIGHT));
		pos.emit      = (row_q >= row_t'(3)) || ((row_q == row_t'(2)) && !col_zero);
		pos.last      = (row_q == row_t'(IMG_HEIGHT + 2)) && col_zero;
		pos.col_first = (qj == '0);
		pos.col_last  = (qj == col_t'(IMG_WIDTH - 1));
		pos.row_first = (qi == '0);
		pos.row_last  = (qi == row_t'(IMG_HEIGHT - 1));
		pos.row_ge2   = (qi >= row_t'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (step) begin
			if (pos.last) begin
				row_q <= '0;
				col_q <= '0;
			end else if (col_q == col_t'(IMG_WIDTH - 1)) begin
				col_q <= '0;
				row_q <= row_q + row_t'(1);
			end else begin
				col_q <= col_q + col_t'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/bsed_window.sv
// Binarisation, binary line buffer and 3x3 Sobel edge decision.
`default_nettype none
module bsed_window (
	input  wire            clk,
	input  wire            step,
	input  bsed_pkg::pix_t red,
	input  bsed_pkg::pix_t green,
	input  bsed_pkg::pix_t blue,
	input  bsed_pkg::thr_t thr,
	input  bsed_pkg::pos_t pos,
	output logic           edge_new
);
	import bsed_pkg::*;

	logic [BL_DEPTH-1:0] bl_q;
	logic [THR_W-1:0]    sum;
	logic                b_new;
	logic                tl, tc, tr, ml, mr, bo_l, bo_c, bo_r;
	logic [2:0]          s_left, s_right, s_top, s_bot;

	always_comb begin
		sum   = THR_W'(red) + THR_W'(green) + THR_W'(blue);
		b_new = pos.in_frame && (sum >= thr);

		tl   = bl_q[2*IMG_WIDTH+1] & ~pos.row_first & ~pos.col_first;
		tc   = bl_q[2*IMG_WIDTH]   & ~pos.row_first;
		tr   = bl_q[2*IMG_WIDTH-1] & ~pos.row_first & ~pos.col_last;
		ml   = bl_q[IMG_WIDTH+1]   & ~pos.col_first;
		mr   = bl_q[IMG_WIDTH-1]   & ~pos.col_last;
		bo_l = bl_q[1]             & ~pos.row_last & ~pos.col_first;
		bo_c = bl_q[0]             & ~pos.row_last;
		bo_r = b_new               & ~pos.row_last & ~pos.col_last;

		s_left  = {2'b00, tl} + {1'b0, ml, 1'b0} + {2'b00, bo_l};
		s_right = {2'b00, tr} + {1'b0, mr, 1'b0} + {2'b00, bo_r};
		s_top   = {2'b00, tl} + {1'b0, tc, 1'b0} + {2'b00, tr};
		s_bot   = {2'b00, bo_l} + {1'b0, bo_c, 1'b0} + {2'b00, bo_r};

		edge_new = pos.q_valid && ((s_left != s_right) || (s_top != s_bot));
	end

	always_ff @(posedge clk) begin
		if (step) begin
			bl_q <= {bl_q[BL_DEPTH-2:0], b_new};
		end
	end

endmodule
`default_nettype wire

FILE: rtl/bsed_link.sv
// Edge line buffer and four-neighbour link test.
`default_nettype none
module bsed_link (
	input  wire            clk,
	input  wire            step,
	input  wire            edge_new,
	input  bsed_pkg::pos_t pos,
	output logic           linked
);
	import bsed_pkg::*;

	logic [EL_DEPTH-1:0] el_q;
	logic                e_c, e_l, e_r, e_u;

	always_comb begin
		e_r    = el_q[IMG_WIDTH-2] & ~pos.col_last;
		e_c    = el_q[IMG_WIDTH-1];
		e_l    = el_q[IMG_WIDTH]   & ~pos.col_first;
		e_u    = el_q[2*IMG_WIDTH-1] & pos.row_ge2;
		linked = e_c & (edge_new | e_u | e_r | e_l);
	end

	always_ff @(posedge clk) begin
		if (step) begin
			el_q <= {el_q[EL_DEPTH-2:0], edge_new};
		end
	end

endmodule
`default_nettype wire

FILE: rtl/binary_sobel_edge_detector_top.sv
// A beat is held in the input register, and its result is then captured in the output register.
// Throughput: one beat per cycle; a stalled result holds the input register and stalls input.
// Output pixel n is triggered by beat n + 2*IMG_WIDTH + 1, pads inside the frame not counted; pad beats flush the tail.
// Reset clears the handshake, the position counter and sets the threshold to 384;
// line buffers are not cleared, border masking hides their contents.
`default_nettype none
module binary_sobel_edge_detector_top (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cfg_we,
	input  bsed_pkg::thr_t cfg_wdata,
	input  wire            in_valid,
	output logic           in_stall,
	input  bsed_pkg::pix_t red,
	input  bsed_pkg::pix_t green,
	input  bsed_pkg::pix_t blue,
	input  wire            is_pad,
	output logic           out_valid,
	input  wire            out_stall,
	output bsed_pkg::pix_t out_value,
	output logic           frame_end
);
	import bsed_pkg::*;

	thr_t thr_q;
	logic valid_s1;
	pix_t red_s1, green_s1, blue_s1;
	logic is_pad_s1;
	logic valid_s2;
	pix_t out_value_s2;
	logic frame_end_s2;

	pos_t pos;
	logic ignore;
	logic adv_s1;
	logic step;
	logic in_take;
	logic edge_new;
	logic linked;

	always_comb begin
		ignore   = pos.in_frame && is_pad_s1;
		adv_s1   = valid_s1 && (ignore || !pos.emit || !valid_s2 || !out_stall);
		step     = adv_s1 && !ignore;
		in_stall = valid_s1 && !adv_s1;
		in_take  = in_valid && !in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			red_s1    <= red;
			green_s1  <= green;
			blue_s1   <= blue;
			is_pad_s1 <= is_pad;
		end
	end

	bsed_pos u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.pos    (pos)
	);

	bsed_window u_window (
		.clk      (clk),
		.step     (step),
		.red      (red_s1),
		.green    (green_s1),
		.blue     (blue_s1),
		.thr      (thr_q),
		.pos      (pos),
		.edge_new (edge_new)
	);

	bsed_link u_link (
		.clk      (clk),
		.step     (step),
		.edge_new (edge_new),
		.pos      (pos),
		.linked   (linked)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step && pos.emit) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && pos.emit) begin
			out_value_s2 <= linked ? PIX_BLACK : PIX_WHITE;
			frame_end_s2 <= pos.last;
		end
	end

	assign out_valid = valid_s2;
	assign out_value = out_value_s2;
	assign frame_end = frame_end_s2;

	a_ignore_hold: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && ignore |=> $stable(pos))
		else $error("ignored pad beat moved the position");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		step && pos.last |=> pos.in_frame && !pos.emit && !pos.q_valid)
		else $error("position not back at frame start after last result");

	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		step && pos.emit |-> !valid_s2 || !out_stall)
		else $error("result register overwritten while stalled");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("stall raised with empty input register");

endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the binary Sobel edge detector top level.
`timescale 1ns / 1ps
module tb;
	import bsed_pkg::*;

	localparam int FRAME_PX      = IMG_WIDTH * IMG_HEIGHT;
	localparam int CYCLE_LIMIT   = 25_000_000;
	localparam int ITEM_COUNT    = 1100;
	localparam int CFG_PERIOD    = 128;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_LIMIT    = 100_000;

	typedef struct packed {
		pix_t red;
		pix_t green;
		pix_t blue;
		logic pad;
	} px_beat_t;

	typedef struct packed {
		pix_t value;
		logic last;
	} out_px_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cfg_we    = 1'b0;
	thr_t cfg_wdata = THR_RESET;
	logic in_valid  = 1'b0;
	pix_t red       = '0;
	pix_t green     = '0;
	pix_t blue      = '0;
	logic is_pad    = 1'b0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	pix_t out_value;
	logic frame_end;

	// top border, left border, threshold boundary, pads inside the frame, single channel bits
	px_beat_t opening_beats [20] = '{
		{8'd0,   8'd0,   8'd0,   1'b0},
		{8'd255, 8'd255, 8'd255, 1'b0},
		{8'd128, 8'd128, 8'd128, 1'b0},
		{8'd128, 8'd128, 8'd127, 1'b0},
		{8'd255, 8'd0,   8'd0,   1'b1},
		{8'd0,   8'd0,   8'd0,   1'b1},
		{8'd255, 8'd129, 8'd0,   1'b0},
		{8'd1,   8'd2,   8'd4,   1'b0},
		{8'd8,   8'd16,  8'd32,  1'b0},
		{8'd64,  8'd128, 8'd0,   1'b0},
		{8'd170, 8'd85,  8'd255, 1'b0},
		{8'd85,  8'd170, 8'd0,   1'b0},
		{8'd255, 8'd255, 8'd255, 1'b1},
		{8'd0,   8'd255, 8'd128, 1'b0},
		{8'd255, 8'd255, 8'd255, 1'b0},
		{8'd255, 8'd255, 8'd255, 1'b0},
		{8'd0,   8'd0,   8'd0,   1'b0},
		{8'd255, 8'd255, 8'd254, 1'b0},
		{8'd0,   8'd0,   8'd1,   1'b0},
		{8'd255, 8'd255, 8'd255, 1'b0}
	};

	out_px_t pending_pixels [$];
	int mismatches     = 0;
	int pixels_checked = 0;
	int unsigned cycle_count = 0;

	logic [IMG_WIDTH-1:0] bin_line  [3];
	logic [IMG_WIDTH-1:0] edge_line [3];
	thr_t        thr_model = THR_RESET;
	int unsigned pos_row   = 0;
	int unsigned pos_col   = 0;

	px_beat_t shade_above [IMG_WIDTH];
	px_beat_t run_shade;
	int       run_shade_left = 0;
	int       burst_left     = 0;

	binary_sobel_edge_detector_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.is_pad    (is_pad),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_value (out_value),
		.frame_end (frame_end)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int bin_px(input int r, input int c);
		if (r < 0 || r >= IMG_HEIGHT || c < 0 || c >= IMG_WIDTH)
			return 0;
		return int'(bin_line[r % 3][c]);
	endfunction

	function automatic bit edge_px(input int r, input int c);
		if (r < 0 || r >= IMG_HEIGHT || c < 0 || c >= IMG_WIDTH)
			return 1'b0;
		return edge_line[r % 3][c];
	endfunction

	function automatic void advance_pos();
		pos_col++;
		if (pos_col >= IMG_WIDTH) begin
			pos_col = 0;
			pos_row++;
		end
	endfunction

	// binarize the new pixel, grade the one a row and a column behind, link the one two rows and a column back
	function automatic bit sobel_link_step(input px_beat_t beat, output out_px_t res);
		int unsigned pos, q, o, sum;
		int qi, qj, oi, oj, gx, gy, w;
		logic linked;
		pos = pos_row * IMG_WIDTH + pos_col;
		res = '0;
		if (pos < FRAME_PX) begin
			if (beat.pad)
				return 1'b0;
			sum = int'(beat.red) + int'(beat.green) + int'(beat.blue);
			bin_line[pos_row % 3][pos_col] = (sum >= int'(thr_model));
		end
		if (pos >= IMG_WIDTH + 1) begin
			q = pos - (IMG_WIDTH + 1);
			if (q < FRAME_PX) begin
				qi = q / IMG_WIDTH;
				qj = q % IMG_WIDTH;
				gx = 0;
				gy = 0;
				for (int k = -1; k <= 1; k++) begin
					w = (k == 0) ? 2 : 1;
					gx += w * (bin_px(qi + k, qj + 1) - bin_px(qi + k, qj - 1));
					gy += w * (bin_px(qi + 1, qj + k) - bin_px(qi - 1, qj + k));
				end
				edge_line[qi % 3][qj] = (gx != 0 || gy != 0);
			end
		end
		if (pos >= 2 * IMG_WIDTH + 1) begin
			o  = pos - (2 * IMG_WIDTH + 1);
			oi = o / IMG_WIDTH;
			oj = o % IMG_WIDTH;
			linked = edge_px(oi, oj) && (edge_px(oi + 1, oj) || edge_px(oi - 1, oj) ||
				edge_px(oi, oj + 1) || edge_px(oi, oj - 1));
			res.value = linked ? PIX_BLACK : PIX_WHITE;
			res.last  = (o == FRAME_PX - 1);
			if (res.last) begin
				pos_row = 0;
				pos_col = 0;
			end else begin
				advance_pos();
			end
			return 1'b1;
		end
		advance_pos();
		return 1'b0;
	endfunction

	function automatic px_beat_t random_shade();
		return {pix_t'($urandom_range(0, 255)), pix_t'($urandom_range(0, 255)),
			pix_t'($urandom_range(0, 255)), 1'b0};
	endfunction

	task automatic send_beat(input px_beat_t beat);
		out_px_t res;
		in_valid <= 1'b1;
		red      <= beat.red;
		green    <= beat.green;
		blue     <= beat.blue;
		is_pad   <= beat.pad;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (sobel_link_step(beat, res))
			pending_pixels = {pending_pixels, res};
	endtask

	task automatic sender_gap();
		int roll, n;
		roll = $urandom_range(0, 99);
		n = 0;
		if (burst_left > 0)
			burst_left--;
		else if (roll < 60)
			n = 0;
		else if (roll < 92)
			n = $urandom_range(1, 3);
		else if (roll < 97)
			burst_left = $urandom_range(20, 200);
		else
			n = $urandom_range(10, 30);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic set_threshold(input thr_t value);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		thr_model = value;
	endtask

	initial begin
		px_beat_t beat;
		thr_t     extreme;
		int roll, target, items_sent, cfg_writes, tail;
		for (int i = 0; i < 3; i++) begin
			bin_line[i]  = '0;
			edge_line[i] = '0;
		end
		for (int c = 0; c < IMG_WIDTH; c++)
			shade_above[c] = random_shade();
		items_sent = 0;
		cfg_writes = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_beats[i]) begin
			send_beat(opening_beats[i]);
			items_sent++;
			sender_gap();
		end

		while (items_sent < ITEM_COUNT) begin
			if (items_sent % CFG_PERIOD == CFG_PERIOD / 2) begin
				if (cfg_writes % 2 == 0) begin
					set_threshold(thr_t'($urandom_range(100, 665)));
				end else begin
					case ((cfg_writes / 2) % 4)
						0:       extreme = thr_t'(0);
						1:       extreme = thr_t'(1023);
						2:       extreme = thr_t'(765);
						default: extreme = thr_t'(766);
					endcase
					set_threshold(extreme);
				end
				cfg_writes++;
			end

			if (pos_row * IMG_WIDTH + pos_col >= FRAME_PX) begin
				// flush: any beat counts, pad or not
				beat = random_shade();
				beat.pad = ($urandom_range(0, 4) != 0);
			end else begin
				if (run_shade_left == 0) begin
					run_shade = random_shade();
					run_shade_left = $urandom_range(1, 40);
				end
				run_shade_left--;
				roll = $urandom_range(0, 99);
				if (roll < 2) begin
					beat = random_shade();
				end else if (roll < 7) begin
					target = int'(thr_model) - int'($urandom_range(0, 1));
					if (target < 0)
						target = 0;
					if (target > 765)
						target = 765;
					beat.red = pix_t'((target > 255) ? 255 : target);
					target -= int'(beat.red);
					beat.green = pix_t'((target > 255) ? 255 : target);
					target -= int'(beat.green);
					beat.blue = pix_t'(target);
				end else if (roll < 60) begin
					beat = shade_above[pos_col];
				end else if (roll < 85) begin
					beat = run_shade;
				end else begin
					beat = random_shade();
				end
				beat.pad = (roll < 2);
				if (!beat.pad)
					shade_above[pos_col] = beat;
			end
			send_beat(beat);
			items_sent++;
			sender_gap();
		end

		in_valid <= 1'b0;
		tail = 0;
		while (pending_pixels.size() != 0 && tail < TAIL_LIMIT) begin
			@(posedge clk);
			tail++;
		end
		repeat (8) @(posedge clk);
		mismatches += pending_pixels.size();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		int n;
		logic long_hold_done;
		long_hold_done = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// hold the output side off while the sender keeps offering beats
			if (!long_hold_done && pixels_checked >= 300) begin
				long_hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (600) @(posedge clk);
			end
			if ($urandom_range(0, 99) < 40) begin
				out_stall <= 1'b1;
				n = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 30);
			end else begin
				out_stall <= 1'b0;
				n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(30, 200);
			end
			repeat (n) @(posedge clk);
		end
	end

	always @(posedge clk) begin : watch_output
		out_px_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: unexpected beat, value %0d frame_end %0b", out_value, frame_end);
			end else begin
				want = pending_pixels.pop_front();
				if (out_value !== want.value || frame_end !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: pixel %0d expected value %0d frame_end %0b, got %0d %0b",
							pixels_checked, want.value, want.last, out_value, frame_end);
				end
				pixels_checked++;
			end
		end
	end

endmodule
